>>> src/bsh32_pkg.sv
// ----------------------------------------------------------------------------
// bsh32_pkg
// Types, constants and state encoding shared by the byte string hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsh32_pkg;

  localparam logic [31:0] MixMulA   = 32'h7feb_352d;
  localparam logic [31:0] MixMulB   = 32'h846c_a68b;
  localparam logic [31:0] ZeroSubst = 32'h0080_0800;
  localparam int unsigned ShiftHi   = 16;
  localparam int unsigned ShiftMid  = 15;

  typedef enum logic [2:0] {
    StIdle,
    StMulA,
    StMulB,
    StMixEnd,
    StFinMulA,
    StFinMulB,
    StFinal
  } state_e;

  // Datapath commands, at most one active in a cycle.
  typedef struct packed {
    logic seed;    // take the accepted word into the running hash
    logic mul_a;   // xor-shift 16, multiply by the first constant
    logic mul_b;   // xor-shift 15, multiply by the second constant
    logic mix_end; // xor-shift 16, store the byte result, prepare the finish
    logic fin;     // last xor-shift, add length, load the output register
  } cmd_t;

  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

>>> src/bsh32_in_if.sv
// ----------------------------------------------------------------------------
// bsh32_in_if
// Input channel: one string byte per word with its framing marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsh32_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] string_length;
  logic        first_item;
  logic        last_item;
  logic        empty_string;

  modport source (output valid, data_byte, string_length, first_item, last_item,
                  empty_string, input ready);
  modport sink   (input valid, data_byte, string_length, first_item, last_item,
                  empty_string, output ready);
endinterface

`default_nettype wire

>>> src/bsh32_out_if.sv
// ----------------------------------------------------------------------------
// bsh32_out_if
// Output channel: one finished 32-bit hash per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsh32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

>>> src/bsh32_ctrl.sv
// ----------------------------------------------------------------------------
// bsh32_ctrl
// Sequencer: steps the shared multiplier through the mix of each byte and
// through the finishing mix after the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh32_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_last_i,
  input  wire                   in_empty_i,
  output logic                  in_ready_o,
  input  bsh32_pkg::status_t    status_i,
  output bsh32_pkg::cmd_t       cmd_o
);

  bsh32_pkg::state_e state_q, state_d;
  logic              last_q, last_d;
  logic              accept;

  assign in_ready_o = (state_q == bsh32_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsh32_pkg::StIdle;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    case (state_q)
      bsh32_pkg::StIdle: begin
        if (accept) begin
          last_d  = in_last_i;
          state_d = in_empty_i ? bsh32_pkg::StFinal : bsh32_pkg::StMulA;
        end
      end
      bsh32_pkg::StMulA:     state_d = bsh32_pkg::StMulB;
      bsh32_pkg::StMulB:     state_d = bsh32_pkg::StMixEnd;
      bsh32_pkg::StMixEnd:   state_d = last_q ? bsh32_pkg::StFinMulA : bsh32_pkg::StIdle;
      bsh32_pkg::StFinMulA:  state_d = bsh32_pkg::StFinMulB;
      bsh32_pkg::StFinMulB:  state_d = bsh32_pkg::StFinal;
      bsh32_pkg::StFinal: begin
        if (status_i.out_free) begin
          state_d = bsh32_pkg::StIdle;
        end
      end
      default:               state_d = bsh32_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      bsh32_pkg::StIdle:     cmd_o.seed    = accept;
      bsh32_pkg::StMulA:     cmd_o.mul_a   = 1'b1;
      bsh32_pkg::StMulB:     cmd_o.mul_b   = 1'b1;
      bsh32_pkg::StMixEnd:   cmd_o.mix_end = 1'b1;
      bsh32_pkg::StFinMulA:  cmd_o.mul_a   = 1'b1;
      bsh32_pkg::StFinMulB:  cmd_o.mul_b   = 1'b1;
      bsh32_pkg::StFinal:    cmd_o.fin     = status_i.out_free;
      default:               cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/bsh32_datapath.sv
// ----------------------------------------------------------------------------
// bsh32_datapath
// Running hash, held length, one shared 32x32 multiplier and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh32_datapath (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  bsh32_pkg::cmd_t       cmd_i,
  output bsh32_pkg::status_t    status_o,
  input  wire  [7:0]            data_byte_i,
  input  wire  [31:0]           string_length_i,
  input  wire                   first_item_i,
  input  wire                   empty_string_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [31:0]           hash_value_o
);

  logic [31:0] acc_q, acc_d;
  logic [31:0] len_q, len_d;
  logic [31:0] h_q, h_d;
  logic [31:0] hash_q, hash_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] seed_base;
  logic [31:0] byte_ext;
  logic [31:0] xs_hi;
  logic [31:0] xs_mid;
  logic [31:0] mul_op;
  logic [31:0] mul_k;
  logic [31:0] mul_res;
  logic [31:0] fin_sum;

  assign byte_ext  = {{24{data_byte_i[7]}}, data_byte_i};
  assign seed_base = first_item_i ? string_length_i : acc_q;
  assign xs_hi     = h_q ^ (h_q >> bsh32_pkg::ShiftHi);
  assign xs_mid    = h_q ^ (h_q >> bsh32_pkg::ShiftMid);

  // The multiplier keeps only the low word of the product.
  assign mul_op  = cmd_i.mul_b ? xs_mid : xs_hi;
  assign mul_k   = cmd_i.mul_b ? bsh32_pkg::MixMulB : bsh32_pkg::MixMulA;
  assign mul_res = mul_op * mul_k;
  assign fin_sum = xs_hi + len_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    acc_d       = acc_q;
    len_d       = len_q;
    h_d         = h_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.seed) begin
      if (empty_string_i) begin
        // An empty string finishes a zero state with a zero length.
        acc_d = '0;
        len_d = '0;
        h_d   = '0;
      end else begin
        len_d = first_item_i ? string_length_i : len_q;
        h_d   = seed_base + byte_ext;
      end
    end
    if (cmd_i.mul_a || cmd_i.mul_b) begin
      h_d = mul_res;
    end
    if (cmd_i.mix_end) begin
      acc_d = xs_hi;
      h_d   = xs_hi ^ len_q;
    end
    if (cmd_i.fin) begin
      hash_d      = (fin_sum == '0) ? bsh32_pkg::ZeroSubst : fin_sum;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    hash_q <= hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

`default_nettype wire

>>> src/byte_string_hash32.sv
// ----------------------------------------------------------------------------
// byte_string_hash32
// Streaming 32-bit hash of byte strings with the lowbias32 mix.
// ----------------------------------------------------------------------------
// Bytes of a string arrive one word at a time; the first word carries the
// string length. Each byte is added in the accept step, multiplied by the
// first and then the second constant on the single shared 32x32 multiplier
// and finished in a last mix step; only then is the next byte taken. The
// last byte adds the finishing mix: both multiplies once more, then a final
// step that adds the length and loads the output register. An empty-string
// word goes straight to that final step. The output register holds a result
// until it is taken while new bytes are accepted; the block waits only when
// a new result is ready and the previous one is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_string_hash32 (
  input  wire         clk_i,
  input  wire         rst_ni,
  bsh32_in_if.sink    in_ch,
  bsh32_out_if.source out_ch
);

  bsh32_pkg::cmd_t    cmd;
  bsh32_pkg::status_t status;

  bsh32_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_last_i  (in_ch.last_item),
    .in_empty_i (in_ch.empty_string),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsh32_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_byte_i     (in_ch.data_byte),
    .string_length_i (in_ch.string_length),
    .first_item_i    (in_ch.first_item),
    .empty_string_i  (in_ch.empty_string),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .hash_value_o    (out_ch.hash_value)
  );

endmodule

`default_nettype wire

>>> src/bsh32_checker.sv
// ----------------------------------------------------------------------------
// bsh32_checker
// Port-level checks for the byte string hash block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh32_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_empty_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [31:0] hash_value_i
);

  // A finished hash is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (hash_value_i != 32'h0))
    else $error("zero hash word delivered");

  // A held result stays put until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(hash_value_i)))
    else $error("output word changed while stalled");

  // Every accepted word keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted during processing");

  // With a free output, an empty string gives the fixed hash via StFinal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_empty_i && !out_valid_i) |->
      ##2 (out_valid_i && (hash_value_i == 32'h0080_0800)))
    else $error("empty string hash missing or wrong");

endmodule

bind byte_string_hash32 bsh32_checker u_bsh32_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .in_empty_i   (in_ch.empty_string),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .hash_value_i (out_ch.hash_value)
);

`default_nettype wire

>>> sim/tb_byte_string_hash32.sv
// ----------------------------------------------------------------------------
// tb_byte_string_hash32
// Self-checking bench for the streaming byte string hash block.
// ----------------------------------------------------------------------------
// Strings are pushed into the block one byte per word. A built-in model of
// the lowbias32 string mix predicts every finished hash. Results are compared
// in order as they leave the block. Both channels idle at random, except in
// the last part of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_byte_string_hash32;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MulFirst   = 32'h7feb_352d;
  localparam logic [31:0] MulSecond  = 32'h846c_a68b;
  localparam logic [31:0] ZeroHash   = 32'h0080_0800;
  localparam int unsigned NumWords   = 1900;
  localparam int unsigned CalmFrom   = 1650;
  localparam int unsigned DrainSlack = 20;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] string_length;
    logic        first_item;
    logic        last_item;
    logic        empty_string;
  } byte_word_t;

  // Running hash of the current string and the queue of finished hashes.
  class hash_tracker;
    logic [31:0] run_hash;
    logic [31:0] held_len;
    logic [31:0] pending_hashes[$];
    int unsigned err_count;
    int unsigned words_seen;
    int unsigned hashes_seen;
    int unsigned empties_seen;

    function new();
      run_hash     = '0;
      held_len     = '0;
      err_count    = 0;
      words_seen   = 0;
      hashes_seen  = 0;
      empties_seen = 0;
    endfunction

    function logic [31:0] lowbias_mix(input logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * MulFirst;
      h = h ^ (h >> 15);
      h = h * MulSecond;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function logic [31:0] finish_hash(input logic [31:0] h, input logic [31:0] len);
      logic [31:0] f;
      f = lowbias_mix(h ^ len) + len;
      return (f == '0) ? ZeroHash : f;
    endfunction

    function void note_word(input byte_word_t w);
      words_seen++;
      if (w.empty_string) begin
        empties_seen++;
        run_hash = '0;
        held_len = '0;
        pending_hashes.push_back(finish_hash('0, '0));
        return;
      end
      if (w.first_item) begin
        run_hash = w.string_length;
        held_len = w.string_length;
      end
      // The byte is a signed character, so it is sign-extended before the add.
      run_hash = lowbias_mix(run_hash + {{24{w.data_byte[7]}}, w.data_byte});
      if (w.last_item) begin
        pending_hashes.push_back(finish_hash(run_hash, held_len));
      end
    endfunction

    function void check_hash(input logic [31:0] got);
      logic [31:0] want;
      hashes_seen++;
      if (pending_hashes.size() == 0) begin
        $error("hash_value: expected none, actual 0x%08h", got);
        err_count++;
        return;
      end
      want = pending_hashes.pop_front();
      if (got !== want) begin
        $error("hash_value: expected 0x%08h, actual 0x%08h", want, got);
        err_count++;
      end
    endfunction

    function int unsigned pending();
      return pending_hashes.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;
  hash_tracker tracker = new();

  bsh32_in_if  in_if ();
  bsh32_out_if out_if ();

  byte_string_hash32 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("byte_string_hash32: mismatch");
    $finish;
  end

  // Receiver: random stall bursts until the calm part of the run.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.check_hash(out_if.hash_value);
    end
  end

  function automatic byte_word_t make_word(input logic [7:0] d, input logic [31:0] len,
                                           input logic f, input logic l, input logic e);
    byte_word_t w;
    w.data_byte     = d;
    w.string_length = len;
    w.first_item    = f;
    w.last_item     = l;
    w.empty_string  = e;
    return w;
  endfunction

  task automatic send_word(input byte_word_t w);
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= w.data_byte;
    in_if.string_length <= w.string_length;
    in_if.first_item    <= w.first_item;
    in_if.last_item     <= w.last_item;
    in_if.empty_string  <= w.empty_string;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_word(w);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // A string of n bytes; the length field may disagree with n, and the
  // last mark may be left off so that the next string starts over.
  task automatic send_string(input int unsigned n, input logic [31:0] len,
                             input bit drop_last);
    for (int unsigned k = 0; k < n; k++) begin
      send_word(make_word(8'($urandom_range(0, 255)), (k == 0) ? len : $urandom(),
                          k == 0, (k == n - 1) && !drop_last, 1'b0));
    end
  endtask

  task automatic wait_drained();
    if (tracker.pending() != 0) begin
      in_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned pick;
    logic [31:0] len;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= '0;
    in_if.string_length <= '0;
    in_if.first_item    <= 1'b0;
    in_if.last_item     <= 1'b0;
    in_if.empty_string  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A byte without a first mark right after reset runs on the reset state.
    send_word(make_word(8'h41, 32'h0, 1'b0, 1'b1, 1'b0));
    // Empty string with every other field set; all of them are ignored.
    send_word(make_word(8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1));
    // Single-byte strings at the byte and length extremes, then a three-byte string.
    send_word(make_word(8'h00, 32'h1, 1'b1, 1'b1, 1'b0));
    send_word(make_word(8'hff, 32'h1, 1'b1, 1'b1, 1'b0));
    send_word(make_word(8'h80, 32'hffff_ffff, 1'b1, 1'b1, 1'b0));
    send_word(make_word(8'h7f, 32'h0, 1'b1, 1'b1, 1'b0));
    send_word(make_word(8'h01, 32'h3, 1'b1, 1'b0, 1'b0));
    send_word(make_word(8'h80, 32'h1234_5678, 1'b0, 1'b0, 1'b0));
    send_word(make_word(8'hfe, 32'h0, 1'b0, 1'b1, 1'b0));
    // After a result the state carries on into an unmarked byte.
    send_word(make_word(8'h55, 32'h0, 1'b0, 1'b1, 1'b0));
    // Declared length does not match the bytes sent.
    send_word(make_word(8'haa, 32'h5, 1'b1, 1'b0, 1'b0));
    send_word(make_word(8'h33, 32'h5, 1'b0, 1'b1, 1'b0));
    // A new first mark restarts a string that never ended.
    send_word(make_word(8'hc3, 32'h2, 1'b1, 1'b0, 1'b0));
    send_word(make_word(8'h3c, 32'h1, 1'b1, 1'b1, 1'b0));
    // An empty string clears a half-done string.
    send_word(make_word(8'h99, 32'h4, 1'b1, 1'b0, 1'b0));
    send_word(make_word(8'h00, 32'h0, 1'b0, 1'b0, 1'b1));
    send_word(make_word(8'h12, 32'h0, 1'b0, 1'b1, 1'b0));
    wait_drained();

    while (tracker.words_seen < NumWords) begin
      if (tracker.words_seen >= CalmFrom) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_word(make_word(8'($urandom_range(0, 255)), $urandom(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b1));
      end else if (pick < 14) begin
        send_word(make_word(8'($urandom_range(0, 255)), $urandom(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b0));
      end else begin
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        len = ($urandom_range(0, 6) == 0) ? $urandom() : n;
        send_string(n, len, $urandom_range(0, 9) == 0);
        if (!calm && $urandom_range(0, 39) == 0) wait_drained();
      end
    end
    // Always close with a complete string.
    send_string(3, 32'd3, 1'b0);
    wait_drained();
    repeat (DrainSlack) @(posedge clk_i);

    if (tracker.pending() != 0) begin
      $error("hash_value: %0d expected hashes never arrived", tracker.pending());
      tracker.err_count++;
    end
    $display("Streamed %0d words, %0d of them empty strings, with idling on both sides.",
             tracker.words_seen, tracker.empties_seen);
    $display("Checked %0d finished hashes against the running prediction.",
             tracker.hashes_seen);
    if (tracker.err_count == 0) begin
      $display("byte_string_hash32: match");
    end else begin
      $display("byte_string_hash32: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
